### rtl/utf8_to_utf16_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_DEFINES_SVH

// Clocked check, off while reset is held.
`define U8U16_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define U8U16_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/u8u16dec_pkg.sv
// Types, widths and codes for the UTF-8 to UTF-16 decoder.
package u8u16dec_pkg;

  localparam int BYTE_W = 8;
  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;
  localparam int REM_W  = 2;

  localparam int MAX_UNITS = 127;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] MAX_LIMIT =
    (MAX_UNITS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_UNITS);

  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(127);

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_TRUNC   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic [CP_W-1:0]   code_point;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  written_count;
    logic              done_res;
  } res_t;

endpackage

### rtl/u8u16dec_core.sv
// Decode state and per-byte next-state / result logic.
`include "utf8_to_utf16_decoder_unit_defines.svh"

module u8u16dec_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  u8u16dec_pkg::item_t           item,
  input  logic [u8u16dec_pkg::CNT_W-1:0] cap,
  output logic                          res_vld,
  output u8u16dec_pkg::res_t            res
);
  import u8u16dec_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt, rem_e, rem_d;
  logic [CP_W-1:0]  acc_r, acc_nxt, acc_e, acc_d;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_e;
  logic             stop_r, stop_nxt, stop_e;
  logic [CNT_W-1:0] limit;
  logic [BYTE_W-1:0] b;
  logic             fail, ok;
  logic [ST_W-1:0]  fail_st;

  assign limit = (cap < MAX_LIMIT) ? cap : MAX_LIMIT;
  assign b     = item.data_byte;

  always_comb begin
    rem_e   = item.first_byte ? '0 : rem_r;
    acc_e   = item.first_byte ? '0 : acc_r;
    cnt_e   = item.first_byte ? '0 : cnt_r;
    stop_e  = item.first_byte ? 1'b0 : stop_r;
    rem_d   = rem_e;
    acc_d   = acc_e;
    fail    = 1'b0;
    ok      = 1'b0;
    fail_st = ST_OK;

    if (!stop_e) begin
      if (rem_e == '0) begin
        priority if (b[7] == 1'b0) begin
          acc_d = CP_W'(b);
          rem_d = REM_W'(0);
        end else if (b[7:6] == 2'b10) begin
          fail    = 1'b1;
          fail_st = ST_INVALID;
        end else if (b[7:5] == 3'b110) begin
          acc_d = CP_W'(b[4:0]);
          rem_d = REM_W'(1);
        end else if (b[7:4] == 4'b1110) begin
          acc_d = CP_W'(b[3:0]);
          rem_d = REM_W'(2);
        end else if (b[7:3] == 5'b11110) begin
          acc_d = CP_W'(b[2:0]);
          rem_d = REM_W'(3);
        end else begin
          fail    = 1'b1;
          fail_st = ST_INVALID;
        end
      end else if (b[7:6] != 2'b10) begin
        fail    = 1'b1;
        fail_st = ST_INVALID;
      end else begin
        acc_d = {acc_e[CP_W-7:0], b[5:0]};
        rem_d = rem_e - REM_W'(1);
      end

      if (!fail) begin
        if (rem_d != '0) begin
          if (item.last_byte) begin
            fail    = 1'b1;
            fail_st = ST_TRUNC;
          end
        end else if (cnt_e >= limit) begin
          fail    = 1'b1;
          fail_st = ST_FULL;
        end else begin
          ok = 1'b1;
        end
      end
    end

    rem_nxt  = rem_d;
    acc_nxt  = acc_d;
    cnt_nxt  = cnt_e;
    stop_nxt = stop_e;
    res_vld  = 1'b0;
    res      = '0;

    if (fail) begin
      rem_nxt           = '0;
      acc_nxt           = '0;
      stop_nxt          = 1'b1;
      res_vld           = 1'b1;
      res.status        = fail_st;
      res.written_count = cnt_e;
      res.done_res      = 1'b1;
    end else if (ok) begin
      cnt_nxt           = cnt_e + CNT_W'(1);
      acc_nxt           = '0;
      stop_nxt          = item.last_byte;
      res_vld           = 1'b1;
      res.code_unit     = acc_d[UNIT_W-1:0];
      res.code_point    = acc_d;
      res.status        = ST_OK;
      res.written_count = cnt_e + CNT_W'(1);
      res.done_res      = item.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else if (en) begin
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

  // a stopped string never holds a partial sequence
  `U8U16_ASSERT(a_stop_clean, stop_r |-> (rem_r == '0 && acc_r == '0), "stopped with partial sequence")

endmodule

### rtl/utf8_to_utf16_decoder_unit.sv
// An accepted item is held in the input register, then its result (if any) in the
// result register. One byte per cycle while the output is not stalled by out_ready;
// decode is one level of logic between the input register and the result register.
// Synchronous active-low reset empties both registers, clears the decode
// state and sets the capacity to 127.
`include "utf8_to_utf16_decoder_unit_defines.svh"

module utf8_to_utf16_decoder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [u8u16dec_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                            in_first_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [u8u16dec_pkg::UNIT_W-1:0] out_code_unit,
  output logic [u8u16dec_pkg::CP_W-1:0]   out_code_point,
  output logic [u8u16dec_pkg::ST_W-1:0]   out_status,
  output logic [u8u16dec_pkg::CNT_W-1:0]  out_written_count,
  output logic                            out_done_res,
  input  logic                            cfg_wr_en,
  input  logic [u8u16dec_pkg::CNT_W-1:0]  cfg_wr_data
);
  import u8u16dec_pkg::*;

  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             out_valid_r;
  res_t             out_res_r;
  logic [CNT_W-1:0] cap_r;
  logic             advance;
  logic             core_vld;
  res_t             core_res;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.data_byte  <= in_data_byte;
      s1_item_r.first_byte <= in_first_byte;
      s1_item_r.last_byte  <= in_last_byte;
    end
  end

  u8u16dec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (advance),
    .item    (s1_item_r),
    .cap     (cap_r),
    .res_vld (core_vld),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= core_vld;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_vld) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_code_unit     = out_res_r.code_unit;
  assign out_code_point    = out_res_r.code_point;
  assign out_status        = out_res_r.status;
  assign out_written_count = out_res_r.written_count;
  assign out_done_res      = out_res_r.done_res;

  `U8U16_ASSERT(a_unit_low, out_valid_r |-> (out_res_r.code_unit == out_res_r.code_point[UNIT_W-1:0]), "code unit not low bits of code point")
  `U8U16_ASSERT(a_err_final, (out_valid_r && out_res_r.status != ST_OK) |-> (out_res_r.code_point == '0 && out_res_r.done_res), "error item not final or not zero")
  `U8U16_ASSERT(a_ok_count, (out_valid_r && out_res_r.status == ST_OK) |-> (out_res_r.written_count != '0), "ok item with zero count")
  `U8U16_ASSERT_ALWAYS(a_rst_empty, !$past(rst_n) |-> (!s1_valid_r && !out_valid_r), "pipeline not empty after reset")

endmodule
